// ----- rtl/dgcc_pkg.sv -----
// shared types and constants for the dependency graph cycle check
package dgcc_pkg;

    localparam int NODES  = 64;
    localparam int NODE_W = $clog2(NODES);
    localparam int CNT_W  = $clog2(NODES + 1);
    localparam int PARTS  = NODES / 8;
    localparam int PART_W = 4;

    typedef logic [NODE_W-1:0] t_node;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [NODES-1:0]  t_row;

    // one queued item after classification
    typedef struct packed {
        logic  store;
        logic  check;
        t_node from_node;
        t_node to_node;
    } t_edge_cmd;

    // queue status seen by the back end
    typedef struct packed {
        logic      empty;
        t_edge_cmd head;
    } t_queue_stat;

    // back end status seen by the front end
    typedef struct packed {
        logic done;
        logic acyclic;
    } t_back_stat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EDGE_WR,
        ST_CNT_RD,
        ST_CNT_PART,
        ST_CNT_WR,
        ST_POP,
        ST_ROW_RD,
        ST_ROW_LD,
        ST_SCAN,
        ST_DEC,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/dependency_graph_cycle_check.sv -----
// top level of the dependency graph cycle check
//
//  port group       dir  handshake            contents
//  edge input       in   start & !busy        i_edge_valid i_from_node i_to_node i_last_edge
//  check result     out  o_result_valid       o_acyclic
//
// an edge item is taken into a two-entry queue; the back end stores it
// with a row and column read-modify-write
// an item with i_last_edge runs the sort: in-degrees for every node (count
// read, partial count, count write), then per sorted node a stack pop and row
// read, plus a count read-modify-write per edge leaving it, then a finish step;
// busy stays high until the result strobe
// after reset and after each result the graph is empty; the row and column
// valid bits clear at once, so no clearing pass is needed
// the result is on the ports for one cycle and cannot be stalled
module dependency_graph_cycle_check (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       i_edge_valid,
    input  logic [5:0] i_from_node,
    input  logic [5:0] i_to_node,
    input  logic       i_last_edge,
    output logic       o_result_valid,
    output logic       o_acyclic
);
    import dgcc_pkg::*;

    t_edge_cmd   cmd;
    t_queue_stat queue_stat;
    t_back_stat  back_stat;
    logic        push, pop, queue_full;

    dgcc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_edge_valid (i_edge_valid),
        .i_from_node  (i_from_node),
        .i_to_node    (i_to_node),
        .i_last_edge  (i_last_edge),
        .i_queue_full (queue_full),
        .i_back       (back_stat),
        .o_push       (push),
        .o_cmd        (cmd)
    );

    dgcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_stat  (queue_stat),
        .o_full  (queue_full)
    );

    dgcc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_queue (queue_stat),
        .o_pop   (pop),
        .o_stat  (back_stat)
    );

    assign o_result_valid = back_stat.done;
    assign o_acyclic      = back_stat.acyclic;

endmodule

// ----- rtl/dgcc_queue.sv -----
// two-entry queue of classified items between front and back end
module dgcc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  dgcc_pkg::t_edge_cmd   i_cmd,
    input  logic                  i_pop,
    output dgcc_pkg::t_queue_stat o_stat,
    output logic                  o_full
);
    import dgcc_pkg::*;

    t_edge_cmd  r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    logic       do_push, do_pop;

    assign do_push = i_push && (r_count != 2'd2);
    assign do_pop  = i_pop && (r_count != 2'd0);

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 2'd1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_stat.empty = (r_count == 2'd0);
    assign o_stat.head  = r_mem[r_rd_ptr];
    assign o_full       = (r_count == 2'd2);

endmodule

// ----- rtl/dgcc_front.sv -----
// front end: takes items, classifies them and feeds the queue
module dgcc_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_edge_valid,
    input  logic [5:0]             i_from_node,
    input  logic [5:0]             i_to_node,
    input  logic                   i_last_edge,
    input  logic                   i_queue_full,
    input  dgcc_pkg::t_back_stat   i_back,
    output logic                   o_push,
    output dgcc_pkg::t_edge_cmd    o_cmd
);
    import dgcc_pkg::*;

    logic r_check_pend, n_check_pend;
    logic accept;
    logic in_range;

    assign busy   = r_check_pend || i_queue_full;
    assign accept = start && !busy;

    // edges to nodes beyond the graph size are dropped
    assign in_range = ({1'b0, i_from_node} < 7'(NODES)) && ({1'b0, i_to_node} < 7'(NODES));

    assign o_cmd.store     = i_edge_valid && in_range;
    assign o_cmd.check     = i_last_edge;
    assign o_cmd.from_node = NODE_W'(i_from_node);
    assign o_cmd.to_node   = NODE_W'(i_to_node);
    assign o_push          = accept && (o_cmd.store || o_cmd.check);

    // hold off new items until the check result is out
    always_comb begin
        n_check_pend = r_check_pend;
        if (accept && i_last_edge) begin
            n_check_pend = 1'b1;
        end else if (i_back.done) begin
            n_check_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_pend <= 1'b0;
        end else begin
            r_check_pend <= n_check_pend;
        end
    end

endmodule

// ----- rtl/dgcc_back.sv -----
// back end: adjacency storage and kahn sort with a ready stack
module dgcc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  dgcc_pkg::t_queue_stat  i_queue,
    output logic                   o_pop,
    output dgcc_pkg::t_back_stat   o_stat
);
    import dgcc_pkg::*;

    // memories: rows by source, columns by destination
    t_row  row_mem [NODES];
    t_row  col_mem [NODES];
    t_cnt  cnt_mem [NODES];
    t_node stk_mem [NODES];

    t_state    r_state, n_state;
    t_edge_cmd r_cmd;
    t_row      r_row_vld, r_col_vld;
    t_row      r_row_q, r_col_q, r_pend;
    logic      r_row_hit, r_col_hit;
    t_cnt      r_cnt_q;
    t_node     r_stk_q;
    t_node     r_idx, r_dst;
    t_cnt      r_depth, r_sorted;
    logic [PART_W-1:0] r_part [PARTS];

    logic  row_rd_en, col_rd_en, cnt_rd_en, stk_rd_en;
    t_node row_rd_addr, col_rd_addr, cnt_rd_addr;
    logic  row_wr_en, col_wr_en, cnt_wr_en, stk_wr_en;
    t_row  row_wr_data, col_wr_data;
    t_cnt  cnt_wr_data, cnt_sum;
    t_node push_node;
    logic  push_want, push, pop_stk;
    t_row  row_eff, col_eff;
    t_node first_set;

    assign row_eff = r_row_hit ? r_row_q : '0;
    assign col_eff = r_col_hit ? r_col_q : '0;

    // lowest set bit of the pending successor mask
    always_comb begin
        first_set = '0;
        for (int i = NODES - 1; i >= 0; i--) begin
            if (r_pend[i]) begin
                first_set = NODE_W'(i);
            end
        end
    end

    always_comb begin
        cnt_sum = '0;
        for (int k = 0; k < PARTS; k++) begin
            cnt_sum = cnt_sum + CNT_W'(r_part[k]);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_queue.empty) begin
                    if (i_queue.head.store) begin
                        n_state = ST_EDGE_WR;
                    end else if (i_queue.head.check) begin
                        n_state = ST_CNT_RD;
                    end
                end
            end
            ST_EDGE_WR:  n_state = r_cmd.check ? ST_CNT_RD : ST_IDLE;
            ST_CNT_RD:   n_state = ST_CNT_PART;
            ST_CNT_PART: n_state = ST_CNT_WR;
            ST_CNT_WR:   n_state = (r_idx == NODE_W'(NODES - 1)) ? ST_POP : ST_CNT_RD;
            ST_POP:      n_state = (r_depth == '0) ? ST_DONE : ST_ROW_RD;
            ST_ROW_RD:   n_state = ST_ROW_LD;
            ST_ROW_LD:   n_state = ST_SCAN;
            ST_SCAN:     n_state = (r_pend == '0) ? ST_POP : ST_DEC;
            ST_DEC:      n_state = ST_SCAN;
            ST_DONE:     n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // outputs and memory controls
    always_comb begin
        o_pop       = 1'b0;
        row_rd_en   = 1'b0;
        row_rd_addr = r_stk_q;
        col_rd_en   = 1'b0;
        col_rd_addr = r_idx;
        cnt_rd_en   = 1'b0;
        cnt_rd_addr = first_set;
        stk_rd_en   = 1'b0;
        row_wr_en   = 1'b0;
        col_wr_en   = 1'b0;
        row_wr_data = row_eff | (t_row'(1) << r_cmd.to_node);
        col_wr_data = col_eff | (t_row'(1) << r_cmd.from_node);
        cnt_wr_en   = 1'b0;
        cnt_wr_data = cnt_sum;
        push_want   = 1'b0;
        push_node   = r_idx;
        pop_stk     = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_pop       = !i_queue.empty;
                row_rd_en   = !i_queue.empty && i_queue.head.store;
                col_rd_en   = row_rd_en;
                row_rd_addr = i_queue.head.from_node;
                col_rd_addr = i_queue.head.to_node;
            end
            ST_EDGE_WR: begin
                row_wr_en = 1'b1;
                col_wr_en = 1'b1;
            end
            ST_CNT_RD: begin
                col_rd_en = 1'b1;
            end
            ST_CNT_WR: begin
                cnt_wr_en = 1'b1;
                push_want = (cnt_sum == '0);
            end
            ST_POP: begin
                pop_stk   = (r_depth != '0);
                stk_rd_en = pop_stk;
            end
            ST_ROW_RD: begin
                row_rd_en = 1'b1;
            end
            ST_SCAN: begin
                cnt_rd_en = (r_pend != '0);
            end
            ST_DEC: begin
                cnt_wr_en   = (r_cnt_q != '0);
                cnt_wr_data = r_cnt_q - CNT_W'(1);
                push_want   = (r_cnt_q == CNT_W'(1));
                push_node   = r_dst;
            end
            default: begin
            end
        endcase
    end

    // a full stack drops the push
    assign push = push_want && (r_depth < CNT_W'(NODES));

    assign o_stat.done    = (r_state == ST_DONE);
    assign o_stat.acyclic = (r_sorted == CNT_W'(NODES));

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_row_vld <= '0;
            r_col_vld <= '0;
            r_depth   <= '0;
            r_sorted  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE) begin
                // clears the graph at once
                r_row_vld <= '0;
                r_col_vld <= '0;
                r_depth   <= '0;
                r_sorted  <= '0;
            end else begin
                if (row_wr_en) begin
                    r_row_vld[r_cmd.from_node] <= 1'b1;
                end
                if (col_wr_en) begin
                    r_col_vld[r_cmd.to_node] <= 1'b1;
                end
                if (push) begin
                    r_depth <= r_depth + CNT_W'(1);
                end else if (pop_stk) begin
                    r_depth  <= r_depth - CNT_W'(1);
                end
                if (pop_stk) begin
                    r_sorted <= r_sorted + CNT_W'(1);
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_queue.head;
        end
        case (r_state)
            ST_IDLE: begin
                r_idx <= '0;
            end
            ST_CNT_PART: begin
                for (int k = 0; k < PARTS; k++) begin
                    r_part[k] <= PART_W'($countones(col_eff[8*k +: 8]));
                end
            end
            ST_CNT_WR: begin
                r_idx <= r_idx + NODE_W'(1);
            end
            ST_ROW_LD: begin
                r_pend <= row_eff;
            end
            ST_SCAN: begin
                if (r_pend != '0) begin
                    r_dst                <= first_set;
                    r_pend[first_set]    <= 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // memories with registered read data
    always_ff @(posedge i_clk) begin
        if (row_rd_en) begin
            r_row_q   <= row_mem[row_rd_addr];
            r_row_hit <= r_row_vld[row_rd_addr];
        end
        if (row_wr_en) begin
            row_mem[r_cmd.from_node] <= row_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (col_rd_en) begin
            r_col_q   <= col_mem[col_rd_addr];
            r_col_hit <= r_col_vld[col_rd_addr];
        end
        if (col_wr_en) begin
            col_mem[r_cmd.to_node] <= col_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cnt_rd_en) begin
            r_cnt_q <= cnt_mem[cnt_rd_addr];
        end
        if (cnt_wr_en) begin
            cnt_mem[(r_state == ST_DEC) ? r_dst : r_idx] <= cnt_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_rd_en) begin
            r_stk_q <= stk_mem[NODE_W'(r_depth - CNT_W'(1))];
        end
        if (push) begin
            stk_mem[NODE_W'(r_depth)] <= push_node;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth <= CNT_W'(NODES))
        else $error("ready stack depth above node count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sorted <= CNT_W'(NODES))
        else $error("more nodes sorted than exist");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |=> (r_row_vld == '0 && r_col_vld == '0 && r_depth == '0))
        else $error("graph not cleared after result");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_want && pop_stk) == 1'b0)
        else $error("stack push and pop in one cycle");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == ST_IDLE))
        else $error("queue popped while back end busy");

endmodule

// ----- sim/tb_dependency_graph_cycle_check.sv -----
// self-checking testbench for the dependency graph cycle check
module tb_dependency_graph_cycle_check;
    timeunit 1ns;
    timeprecision 1ps;

    import dgcc_pkg::*;

    // what a stimulus row promises for its result
    typedef enum logic [1:0] {
        W_CYCLE,
        W_ACYCLIC,
        W_MODEL
    } t_want;

    typedef struct packed {
        logic  ev;
        t_node src;
        t_node dst;
        logic  last;
        t_want want;
    } t_stim_row;

    localparam int PLAN_ROWS = 23;
    localparam int ITEM_TARGET = 1400;
    localparam int MAX_SHOWN = 10;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  start = 1'b0;
    logic  busy;
    logic  i_edge_valid = 1'b0;
    t_node i_from_node = '0;
    t_node i_to_node = '0;
    logic  i_last_edge = 1'b0;
    logic  o_result_valid;
    logic  o_acyclic;

    t_row      edge_rows [NODES];
    bit        acyclic_q [$];
    int        mismatches = 0;
    int        items_sent = 0;
    t_stim_row plan [PLAN_ROWS];

    dependency_graph_cycle_check dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_edge_valid   (i_edge_valid),
        .i_from_node    (i_from_node),
        .i_to_node      (i_to_node),
        .i_last_edge    (i_last_edge),
        .o_result_valid (o_result_valid),
        .o_acyclic      (o_acyclic)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

    // kahn sort over the stored matrix, every node takes part
    function automatic bit graph_is_acyclic();
        int indeg [NODES];
        int ready [NODES];
        int depth;
        int sorted;
        int s;
        depth = 0;
        sorted = 0;
        for (int d = 0; d < NODES; d++) begin
            indeg[d] = 0;
        end
        for (int r = 0; r < NODES; r++) begin
            for (int d = 0; d < NODES; d++) begin
                if (edge_rows[r][d]) indeg[d]++;
            end
        end
        for (int d = 0; d < NODES; d++) begin
            if (indeg[d] == 0) begin
                ready[depth] = d;
                depth++;
            end
        end
        while (depth > 0) begin
            depth--;
            s = ready[depth];
            sorted++;
            for (int d = 0; d < NODES; d++) begin
                if (edge_rows[s][d] && indeg[d] > 0) begin
                    indeg[d]--;
                    if (indeg[d] == 0) begin
                        ready[depth] = d;
                        depth++;
                    end
                end
            end
        end
        return sorted == NODES;
    endfunction

    // present one item, hold it until taken, then update the graph copy
    task automatic send_item(input logic ev, input t_node src, input t_node dst,
                             input logic last, input t_want want, input int gap);
        bit ok;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_edge_valid <= ev;
        i_from_node  <= src;
        i_to_node    <= dst;
        i_last_edge  <= last;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (ev || last) items_sent++;
        if (ev) edge_rows[src][dst] = 1'b1;
        if (last) begin
            ok = graph_is_acyclic();
            acyclic_q.push_back((want == W_MODEL) ? ok : (want == W_ACYCLIC));
            for (int r = 0; r < NODES; r++) edge_rows[r] = '0;
        end
    endtask

    // one random graph; ranks are mapped to nodes through an xor key
    task automatic run_graph();
        int    mode;
        int    span;
        int    key;
        int    n_edges;
        int    odd_at;
        int    ra;
        int    rb;
        bit    burst;
        t_node a;
        t_node b;
        t_node prev_a;
        t_node prev_b;
        mode = $urandom_range(0, 9);
        span = $urandom_range(2, NODES);
        key = $urandom_range(0, NODES - 1);
        n_edges = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 16);
        if ($urandom_range(0, 19) == 0) n_edges = 0;
        odd_at = (n_edges > 0) ? $urandom_range(0, n_edges - 1) : -1;
        burst = ($urandom_range(0, 3) == 0);
        prev_a = '0;
        prev_b = '0;
        for (int i = 0; i < n_edges; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_item(1'b0, t_node'($urandom), t_node'($urandom), 1'b0, W_MODEL,
                          burst ? 0 : $urandom_range(0, 5));
            if (i > 0 && $urandom_range(0, 7) == 0) begin
                a = prev_a;
                b = prev_b;
            end else if (mode >= 7 && mode <= 8) begin
                a = t_node'($urandom_range(0, span - 1) ^ key);
                b = t_node'($urandom_range(0, span - 1) ^ key);
            end else begin
                ra = $urandom_range(0, span - 2);
                rb = $urandom_range(ra + 1, span - 1);
                a = t_node'(ra ^ key);
                b = t_node'(rb ^ key);
                // back edge closes a loop, or a self-loop
                if (i == odd_at && (mode == 5 || mode == 6)) begin
                    a = t_node'(rb ^ key);
                    b = t_node'(ra ^ key);
                end else if (i == odd_at && mode == 9) begin
                    b = a;
                end
            end
            prev_a = a;
            prev_b = b;
            send_item(1'b1, a, b, (i == n_edges - 1) && (mode[0] == 1'b1), W_MODEL,
                      burst ? 0 : $urandom_range(0, 5));
        end
        if (n_edges == 0 || mode[0] == 1'b0)
            send_item(1'b0, t_node'($urandom), t_node'($urandom), 1'b1, W_MODEL,
                      burst ? 0 : $urandom_range(0, 5));
    endtask

    always @(posedge i_clk) begin : check_result
        bit want;
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (acyclic_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: acyclic=%b", o_acyclic);
            end else begin
                want = acyclic_q.pop_front();
                if (o_acyclic !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("acyclic mismatch: expected %b, got %b", want, o_acyclic);
                end
            end
        end
    end

    initial begin : stimulus
        int graphs;
        graphs = 0;
        for (int r = 0; r < NODES; r++) edge_rows[r] = '0;
        plan = '{
            '{1'b0, 6'd0,  6'd0,  1'b1, W_ACYCLIC},  // empty graph
            '{1'b1, 6'd0,  6'd0,  1'b1, W_CYCLE},    // self-loop at the low end
            '{1'b1, 6'd63, 6'd63, 1'b1, W_CYCLE},    // self-loop at the high end
            '{1'b1, 6'd0,  6'd63, 1'b1, W_ACYCLIC},
            '{1'b1, 6'd63, 6'd0,  1'b0, W_MODEL},
            '{1'b1, 6'd0,  6'd63, 1'b1, W_CYCLE},    // two-node loop
            '{1'b1, 6'd5,  6'd6,  1'b0, W_MODEL},
            '{1'b1, 6'd5,  6'd6,  1'b0, W_MODEL},
            '{1'b1, 6'd5,  6'd6,  1'b1, W_ACYCLIC},  // duplicates collapse
            '{1'b1, 6'd1,  6'd2,  1'b0, W_MODEL},
            '{1'b0, 6'd2,  6'd1,  1'b0, W_MODEL},    // ignored, would close a loop
            '{1'b0, 6'd0,  6'd0,  1'b1, W_ACYCLIC},
            '{1'b1, 6'd10, 6'd11, 1'b0, W_MODEL},
            '{1'b1, 6'd11, 6'd10, 1'b1, W_CYCLE},    // edge stored, then checked
            '{1'b1, 6'd21, 6'd42, 1'b0, W_MODEL},
            '{1'b1, 6'd42, 6'd63, 1'b0, W_MODEL},
            '{1'b1, 6'd63, 6'd21, 1'b1, W_CYCLE},
            '{1'b1, 6'd1,  6'd2,  1'b0, W_MODEL},
            '{1'b1, 6'd1,  6'd3,  1'b0, W_MODEL},
            '{1'b1, 6'd2,  6'd4,  1'b0, W_MODEL},
            '{1'b1, 6'd3,  6'd4,  1'b1, W_MODEL},
            '{1'b0, 6'd63, 6'd63, 1'b0, W_MODEL},
            '{1'b1, 6'd62, 6'd61, 1'b1, W_MODEL}
        };
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (plan[k])
            send_item(plan[k].ev, plan[k].src, plan[k].dst, plan[k].last, plan[k].want,
                      $urandom_range(0, 5));
        while (items_sent < PLAN_ROWS + ITEM_TARGET) begin
            // now and then let the block drain completely
            if (graphs % 8 == 7 && acyclic_q.size() != 0) begin
                start <= 1'b0;
                while (acyclic_q.size() != 0) @(posedge i_clk);
            end
            run_graph();
            graphs++;
        end
        start <= 1'b0;
        while (acyclic_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
